### src/mbe_pkg.sv
package mbe_pkg;

    // Fixed-point format of z and c, and width of the iteration counter
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int IN_W        = 32;

    // |x|, |y| <= 2.0 once a point survives the test: 2^(FRAC_BITS+1) plus sign
    localparam int XW = FRAC_BITS + 3;
    // Full signed product width
    localparam int PW = 2 * XW;
    // Width of an updated coordinate: shifted product term plus c, one carry bit
    localparam int NW = ((IN_W > FRAC_BITS + 4) ? IN_W : FRAC_BITS + 4) + 1;

    // Escape bound on a single coordinate (2.0) and on |z|^2 (4.0)
    localparam logic signed [NW-1:0] BOUND = NW'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [PW-1:0] THR   = PW'(1) <<< (2 * FRAC_BITS + 2);

    localparam logic [COUNT_WIDTH-1:0] RESET_LIMIT = COUNT_WIDTH'(100);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SQX,
        S_SQY,
        S_XY,
        S_TEST,
        S_DONE
    } t_state;

endpackage

### src/mbe_mul.sv
module mbe_mul (
    input  logic                              i_clk,
    input  logic signed [mbe_pkg::XW-1:0]     i_a,
    input  logic signed [mbe_pkg::XW-1:0]     i_b,
    output logic signed [mbe_pkg::PW-1:0]     o_p
);

    logic signed [mbe_pkg::PW-1:0] r_p;

    // Register the full-width signed product
    always_ff @(posedge i_clk) begin
        r_p <= mbe_pkg::PW'(i_a) * mbe_pkg::PW'(i_b);
    end

    assign o_p = r_p;

endmodule

### src/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit.
// Input channel (i_in_valid / o_in_ready) carries one point c as i_c_real and
// i_c_imag, signed fixed point with 28 fraction bits. Output channel
// (o_out_valid / i_out_ready) returns o_escape_count and o_inside_res for
// each point, in order. i_cfg_we / i_cfg_data write the iteration limit; it
// resets to 100 and is to be written by the user only while the unit is
// idle; the unit itself does not enforce this. One signed multiplier, shared
// under a small sequencer, forms x*x, y*y and x*y in turn, so every iteration
// steps through S_ADD, S_SQX, S_SQY, S_XY and S_TEST. o_escape_count gives
// the iteration k on which |z|^2 passes 4.0 or a coordinate already lies
// past 2.0, or the limit when the point stays inside.
// One point is worked on at a time; o_in_ready is high only while the
// sequencer is idle, so the next point is accepted only after the result is
// loaded.
// The result sits in an output register, so a new point is accepted while a
// finished result waits. If the receiver still stalls when the next result
// is done, the sequencer holds that result until the output register frees.
// Reset (i_rst_n, synchronous, active low) drops any point in progress,
// empties the output register and sets the limit back to 100.
module mandelbrot_escape_time (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mbe_pkg::COUNT_WIDTH-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [mbe_pkg::IN_W-1:0]        i_c_real,
    input  logic signed [mbe_pkg::IN_W-1:0]        i_c_imag,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [mbe_pkg::COUNT_WIDTH-1:0]        o_escape_count,
    output logic                                   o_inside_res
);

    mbe_pkg::t_state r_state, n_state;

    logic [mbe_pkg::COUNT_WIDTH-1:0]  r_limit;
    logic signed [mbe_pkg::IN_W-1:0]  r_cr, n_cr, r_ci, n_ci;
    logic signed [mbe_pkg::NW-1:0]    r_x, n_x, r_y, n_y;
    logic signed [mbe_pkg::PW-1:0]    r_xx, n_xx, r_yy, n_yy, r_xy, n_xy;
    logic [mbe_pkg::COUNT_WIDTH-1:0]  r_cnt, n_cnt;
    logic [mbe_pkg::COUNT_WIDTH-1:0]  r_res_count, n_res_count;
    logic                             r_res_inside, n_res_inside;
    logic                             r_ov, n_ov;
    logic [mbe_pkg::COUNT_WIDTH-1:0]  r_out_count, n_out_count;
    logic                             r_out_inside, n_out_inside;

    logic signed [mbe_pkg::XW-1:0]    mul_a, mul_b;
    logic signed [mbe_pkg::PW-1:0]    mul_p;
    logic signed [mbe_pkg::PW-1:0]    diff, diff_sh, xy_sh, mag_sum;
    logic signed [mbe_pkg::NW-1:0]    nx, ny, cr_ext, ci_ext;
    logic                             out_of_bound, esc_sum, out_free;

    // Shared multiplier
    mbe_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Select multiplier operands by phase
    always_comb begin
        case (r_state)
            mbe_pkg::S_SQX: begin
                mul_a = r_x[mbe_pkg::XW-1:0];
                mul_b = r_x[mbe_pkg::XW-1:0];
            end
            mbe_pkg::S_SQY: begin
                mul_a = r_y[mbe_pkg::XW-1:0];
                mul_b = r_y[mbe_pkg::XW-1:0];
            end
            default: begin
                mul_a = r_x[mbe_pkg::XW-1:0];
                mul_b = r_y[mbe_pkg::XW-1:0];
            end
        endcase
    end

    // Next z: x' = floor((x^2 - y^2) / 2^F) + cr, y' = floor(2xy / 2^F) + ci
    assign diff    = r_xx - r_yy;
    assign diff_sh = diff >>> mbe_pkg::FRAC_BITS;
    assign xy_sh   = r_xy >>> (mbe_pkg::FRAC_BITS - 1);
    assign cr_ext  = {{(mbe_pkg::NW - mbe_pkg::IN_W){r_cr[mbe_pkg::IN_W-1]}}, r_cr};
    assign ci_ext  = {{(mbe_pkg::NW - mbe_pkg::IN_W){r_ci[mbe_pkg::IN_W-1]}}, r_ci};
    assign nx      = diff_sh[mbe_pkg::NW-1:0] + cr_ext;
    assign ny      = xy_sh[mbe_pkg::NW-1:0] + ci_ext;

    // Escape tests: coordinate bound, then |z|^2 > 4 on exact squares
    assign out_of_bound = (r_x > mbe_pkg::BOUND) || (r_x < -mbe_pkg::BOUND) ||
                          (r_y > mbe_pkg::BOUND) || (r_y < -mbe_pkg::BOUND);
    assign mag_sum      = r_xx + r_yy;
    assign esc_sum      = mag_sum > mbe_pkg::THR;

    assign out_free = !r_ov || i_out_ready;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbe_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_limit <= mbe_pkg::RESET_LIMIT;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cr         <= n_cr;
        r_ci         <= n_ci;
        r_x          <= n_x;
        r_y          <= n_y;
        r_xx         <= n_xx;
        r_yy         <= n_yy;
        r_xy         <= n_xy;
        r_cnt        <= n_cnt;
        r_res_count  <= n_res_count;
        r_res_inside <= n_res_inside;
        r_out_count  <= n_out_count;
        r_out_inside <= n_out_inside;
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cr         = r_cr;
        n_ci         = r_ci;
        n_x          = r_x;
        n_y          = r_y;
        n_xx         = r_xx;
        n_yy         = r_yy;
        n_xy         = r_xy;
        n_cnt        = r_cnt;
        n_res_count  = r_res_count;
        n_res_inside = r_res_inside;
        n_ov         = r_ov && !i_out_ready;
        n_out_count  = r_out_count;
        n_out_inside = r_out_inside;
        o_in_ready   = 1'b0;

        case (r_state)
            mbe_pkg::S_IDLE: begin
                // Accept a point and start from z = 0
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cr    = i_c_real;
                    n_ci    = i_c_imag;
                    n_xx    = '0;
                    n_yy    = '0;
                    n_xy    = '0;
                    n_cnt   = '0;
                    n_state = mbe_pkg::S_ADD;
                end
            end
            mbe_pkg::S_ADD: begin
                // Stop at the limit, else form the next z
                if (r_cnt == r_limit) begin
                    n_res_count  = r_limit;
                    n_res_inside = 1'b1;
                    n_state      = mbe_pkg::S_DONE;
                end else begin
                    n_x     = nx;
                    n_y     = ny;
                    n_state = mbe_pkg::S_SQX;
                end
            end
            mbe_pkg::S_SQX: begin
                // x*x starts; drop out early if a coordinate is past 2.0
                if (out_of_bound) begin
                    n_res_count  = r_cnt;
                    n_res_inside = 1'b0;
                    n_state      = mbe_pkg::S_DONE;
                end else begin
                    n_state = mbe_pkg::S_SQY;
                end
            end
            mbe_pkg::S_SQY: begin
                n_xx    = mul_p;
                n_state = mbe_pkg::S_XY;
            end
            mbe_pkg::S_XY: begin
                n_yy    = mul_p;
                n_state = mbe_pkg::S_TEST;
            end
            mbe_pkg::S_TEST: begin
                // Capture x*y and test |z|^2 against 4.0
                n_xy = mul_p;
                if (esc_sum) begin
                    n_res_count  = r_cnt;
                    n_res_inside = 1'b0;
                    n_state      = mbe_pkg::S_DONE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = mbe_pkg::S_ADD;
                end
            end
            mbe_pkg::S_DONE: begin
                // Hand the result to the output register once it frees
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out_count  = r_res_count;
                    n_out_inside = r_res_inside;
                    n_state      = mbe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbe_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_ov;
    assign o_escape_count = r_out_count;
    assign o_inside_res   = r_out_inside;

endmodule

### test/testbench.sv
module testbench;

    localparam int CYCLE_LIMIT = 6_000_000;

    // Handy points in signed fixed point with FRAC_BITS fraction bits
    localparam logic signed [mbe_pkg::IN_W-1:0] ONE      = 32'sh1000_0000;
    localparam logic signed [mbe_pkg::IN_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [mbe_pkg::IN_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // Random region that covers the set: real [-2.1, 0.6], imag [-1.3, 1.3]
    localparam logic signed [mbe_pkg::IN_W-1:0] RE_LOW  = -32'sd563714458;
    localparam int unsigned                     RE_SPAN = 724775732;
    localparam logic signed [mbe_pkg::IN_W-1:0] IM_LOW  = -32'sd348966093;
    localparam int unsigned                     IM_SPAN = 697932186;

    typedef struct packed {
        logic [mbe_pkg::COUNT_WIDTH-1:0] count;
        logic                            in_set;
    } t_escape_result;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_cfg_we = 1'b0;
    logic [mbe_pkg::COUNT_WIDTH-1:0]        i_cfg_data = '0;
    logic                                   i_in_valid = 1'b0;
    logic                                   o_in_ready;
    logic signed [mbe_pkg::IN_W-1:0]        i_c_real = '0;
    logic signed [mbe_pkg::IN_W-1:0]        i_c_imag = '0;
    logic                                   o_out_valid;
    logic                                   i_out_ready = 1'b0;
    logic [mbe_pkg::COUNT_WIDTH-1:0]        o_escape_count;
    logic                                   o_inside_res;

    t_escape_result                         expected_escapes[$];
    t_escape_result                         oldest_escape;
    logic [mbe_pkg::COUNT_WIDTH-1:0]        limit_setting = mbe_pkg::RESET_LIMIT;
    logic                                   no_idle = 1'b0;
    int                                     mismatch_count = 0;
    int                                     cycle_count = 0;

    mandelbrot_escape_time DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_c_real       (i_c_real),
        .i_c_imag       (i_c_imag),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_escape_count (o_escape_count),
        .o_inside_res   (o_inside_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Iterate z = z*z + c from z = 0 with exact products and floor shifts
    function automatic t_escape_result predict_escape(
            input logic signed [mbe_pkg::IN_W-1:0] c_re,
            input logic signed [mbe_pkg::IN_W-1:0] c_im);
        logic signed [127:0] zx;
        logic signed [127:0] zy;
        logic signed [127:0] nx;
        logic signed [127:0] ny;
        logic signed [127:0] mag2;
        logic signed [127:0] four;
        t_escape_result      res;
        int unsigned         n;
        zx = '0;
        zy = '0;
        four = 128'sd1 <<< (2 * mbe_pkg::FRAC_BITS + 2);
        res.count = limit_setting;
        res.in_set = 1'b1;
        for (n = 0; n < limit_setting; n++) begin
            nx = ((zx * zx - zy * zy) >>> mbe_pkg::FRAC_BITS) + c_re;
            ny = ((zx * zy) >>> (mbe_pkg::FRAC_BITS - 1)) + c_im;
            mag2 = nx * nx + ny * ny;
            if (mag2 > four) begin
                res.count = n[mbe_pkg::COUNT_WIDTH-1:0];
                res.in_set = 1'b0;
                break;
            end
            zx = nx;
            zy = ny;
        end
        return res;
    endfunction

    // Offer one point after a random gap and hold it until the transaction completes
    task automatic send_point(input logic signed [mbe_pkg::IN_W-1:0] c_re,
                              input logic signed [mbe_pkg::IN_W-1:0] c_im);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_c_real   <= c_re;
        i_c_imag   <= c_im;
        do @(posedge i_clk); while (!o_in_ready);
        expected_escapes = {expected_escapes, predict_escape(c_re, c_im)};
    endtask

    // Drop valid and wait until every result is back and the unit has settled
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_escapes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [mbe_pkg::COUNT_WIDTH-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_setting = value;
    endtask

    // Receiver: stall a random number of cycles before each transaction
    initial begin
        int unsigned stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_escapes.size() == 0) begin
                $display("%0t: unexpected result count=%0d inside=%0b",
                         $time, o_escape_count, o_inside_res);
                mismatch_count++;
            end else begin
                oldest_escape = expected_escapes.pop_front();
                if (o_escape_count !== oldest_escape.count) begin
                    $display("%0t: escape_count expected %0d actual %0d",
                             $time, oldest_escape.count, o_escape_count);
                    mismatch_count++;
                end
                if (o_inside_res !== oldest_escape.in_set) begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, oldest_escape.in_set, o_inside_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Limit from reset: boundary points, slow escapes and extreme patterns
    task automatic test_reset_limit();
        send_point('0, '0);
        send_point(-2 * ONE, '0);
        send_point(ONE / 4, '0);
        send_point(2 * ONE, '0);
        send_point(2 * ONE + 1, '0);
        send_point('0, ONE);
        send_point('0, -2 * ONE);
        send_point(-ONE * 3 / 4, 32'sh0199_999A);
        send_point(32'sh0428_F5C3, '0);
        send_point(MOST_NEG, MOST_NEG);
        send_point(MOST_POS, MOST_POS);
        send_point(MOST_POS, MOST_NEG);
        send_point(-32'sd1, -32'sd1);
    endtask

    // No iteration runs at all
    task automatic test_zero_limit();
        write_limit('0);
        send_point('0, '0);
        send_point(MOST_NEG, MOST_NEG);
        send_point(2 * ONE + 1, '0);
    endtask

    // Escape on the last allowed iteration versus staying inside
    task automatic test_short_limits();
        write_limit(16'd1);
        send_point(2 * ONE, '0);
        send_point(2 * ONE + 1, '0);
        write_limit(16'd2);
        send_point(2 * ONE, '0);
        send_point('0, ONE);
    endtask

    task automatic test_max_limit();
        write_limit('1);
        send_point('0, '0);
        send_point(32'sh0428_F5C3, '0);
        send_point(-2 * ONE - 1, '0);
    endtask

    // Random points in phases of different limits, mostly near the set
    task automatic test_random();
        logic [mbe_pkg::COUNT_WIDTH-1:0]  phase_limits [4];
        logic signed [mbe_pkg::IN_W-1:0]  c_re;
        logic signed [mbe_pkg::IN_W-1:0]  c_im;
        int unsigned                      sel;
        phase_limits = '{16'd100, 16'd1, 16'd0, 16'd400};
        phase_limits[2] = $urandom_range(2, 60);
        for (int p = 0; p < 4; p++) begin
            write_limit(phase_limits[p]);
            for (int k = 0; k < 200; k++) begin
                // hold both sides busy for a stretch every fifty points
                no_idle = (k % 50) < 8;
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    c_re = RE_LOW + $urandom_range(0, RE_SPAN);
                    c_im = IM_LOW + $urandom_range(0, IM_SPAN);
                end else begin
                    c_re = $urandom;
                    c_im = $urandom;
                end
                send_point(c_re, c_im);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_limit();
        test_zero_limit();
        test_short_limits();
        test_max_limit();
        test_random();
        drain_results();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
src/mbe_pkg.sv
src/mbe_mul.sv
src/mandelbrot_escape_time.sv
test/testbench.sv
